>>> rtl/lpdi_pkg.sv
// ----------------------------------------------------------------------------
// lpdi_pkg
// Shared command, status and register codes and constants for the lidar point projector.
// ----------------------------------------------------------------------------
package lpdi_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_PROJECT = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  localparam logic [2:0] ST_OUTSIDE  = 3'd0;
  localparam logic [2:0] ST_NO_DEPTH = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_KEPT     = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_SCALE  = 2'd2;

  // quotient bits of the pixel divider, enough for 4096 columns or rows
  localparam int QUOT_BITS = 13;

  localparam logic [15:0] SAT_DEPTH = 16'hFFFF;

endpackage

>>> rtl/lpdi_ram.sv
// ----------------------------------------------------------------------------
// lpdi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/lidar_point_depth_image_projector.sv
// ----------------------------------------------------------------------------
// lidar_point_depth_image_projector
// Pinhole projection of lidar points into a depth image and an intensity
// image, with a z-buffer that keeps the nearest nonzero depth per pixel.
// ----------------------------------------------------------------------------
// usage
//   command channel: a word is taken on a clock edge with start high and busy
//   low. cmd selects load coefficient, clear images, project point, read pixel.
//   result: done is high for one cycle with status, pixel_depth and
//   pixel_intensity; the receiver must take it then, it cannot stall.
//   config: cfg_valid/cfg_ready write image_width, image_height and
//   depth_scale by cfg_index; cfg_ready is always high, write only when idle.
// operation
//   load coefficient: result in the cycle after the command
//   read pixel: S_RREQ then S_RDAT; next cycle for a pixel outside the stores
//   project point: the shared 33x33 multiplier runs 16 multiply-accumulate
//   steps plus 2 depth products, then the bit-serial divider runs 13 steps
//   each for column and row, then one read-modify-write on the image memory;
//   early exits come when w is not positive or the column is out of range
//   clear images: every memory word is zeroed, one memory word per cycle
// reset
//   coefficients go to zero and the block runs the same clearing pass
//   (busy high, no result word) before it takes
//   a command
// ----------------------------------------------------------------------------
module lidar_point_depth_image_projector #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 512,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [3:0]         coef_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic [15:0]        reflectance,
  input  logic [10:0]        pixel_col,
  input  logic [8:0]         pixel_row,
  // result
  output logic               done,
  output logic [2:0]         status,
  output logic [15:0]        pixel_depth,
  output logic [15:0]        pixel_intensity,
  // configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NPIX   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(NPIX);
  localparam int QB     = lpdi_pkg::QUOT_BITS;
  // accumulator width: the 66-bit product shifted right by FRAC_BITS
  localparam int AW     = 66 - FRAC_BITS;
  localparam int HW     = AW - 32;
  localparam int NUM_W  = AW + 2;
  localparam int DEN_W  = AW + 1;
  localparam int REM_W  = AW + QB + 1;
  localparam int TW     = AW + 33;

  localparam logic [QB-1:0]     MAXW_Q = QB'(MAX_WIDTH);
  localparam logic [QB-1:0]     MAXH_Q = QB'(MAX_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_A = ADDR_W'(NPIX - 1);
  localparam logic [TW-1:0]     SAT_THR  = TW'(17'h1FFFF) << (2 * FRAC_BITS - 1);
  localparam logic [TW-1:0]     HALF_LSB = TW'(1) << (2 * FRAC_BITS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MAC, S_DLO, S_DHI, S_DSUM, S_DSAT,
    S_DIVI, S_DIVS, S_DIVE, S_ADDR, S_RD, S_WR, S_RREQ, S_RDAT
  } state_t;

  state_t state;

  // configuration registers
  logic [11:0] image_width;
  logic [9:0]  image_height;
  logic [31:0] depth_scale;

  logic [31:0] coef [16];

  // latched point
  logic signed [31:0] px, py, pz;
  logic [15:0]        refl;

  // multiply-accumulate sequencer
  logic [4:0]           idx;
  logic signed [AW-1:0] term;
  logic [1:0]           term_row;
  logic                 term_vld;
  logic signed [AW-1:0] acc [4];   // u, v, w, d

  // depth scaling
  logic [63:0]    plo;
  logic [HW+31:0] phi;
  logic [TW-1:0]  total;
  logic [15:0]    sd;

  // pixel divider
  logic             dsel;          // 0 column, 1 row
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] dsh;
  logic [QB-1:0]    quot;
  logic [3:0]       bcnt;
  logic             ovf;
  logic             neg;
  logic [QB-1:0]    colq;
  logic [QB-1:0]    rowq;

  logic [ADDR_W-1:0] addr;
  // clearing pass started by a command, answered with a result word
  logic              clr_cmd;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  // ram
  logic        ram_we;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  // effective image size, limited by the stores
  logic [QB-1:0] eff_w, eff_h;
  assign eff_w = ({1'b0, image_width} < MAXW_Q) ? {1'b0, image_width} : MAXW_Q;
  assign eff_h = (QB'(image_height) < MAXH_Q) ? QB'(image_height) : MAXH_Q;

  // operands for the shared multiplier
  logic signed [31:0] pt_sel;
  always_comb begin
    case (idx[1:0])
      2'd0:    pt_sel = px;
      2'd1:    pt_sel = py;
      default: pt_sel = pz;
    endcase
    case (state)
      S_DLO: begin
        mul_a = {1'b0, acc[3][31:0]};
        mul_b = {1'b0, depth_scale};
      end
      S_DHI: begin
        mul_a = 33'(acc[3][AW-1:32]);
        mul_b = {1'b0, depth_scale};
      end
      default: begin
        mul_a = 33'(signed'(coef[idx[3:0]]));
        mul_b = 33'(pt_sel);
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // divider setup for the selected row
  logic signed [AW-1:0] div_a;
  logic [AW-1:0]        mag;
  logic [NUM_W-1:0]     num;
  logic [DEN_W-1:0]     den;
  always_comb begin
    div_a = dsel ? acc[1] : acc[0];
    mag   = div_a[AW-1] ? AW'(-div_a) : AW'(div_a);
    num   = {1'b0, mag, 1'b0} + NUM_W'(acc[2]);
    den   = {acc[2], 1'b0};
  end

  logic [REM_W-1:0] trial;
  logic             trial_ok;
  assign trial    = rem - dsh;
  assign trial_ok = (rem >= dsh);

  logic [QB-1:0] div_lim;
  logic          div_pass;
  assign div_lim  = dsel ? eff_h : eff_w;
  assign div_pass = !ovf && !(neg && (quot != '0)) && (quot < div_lim);

  // z-buffer decision on the word read back
  logic [15:0] cur_depth;
  logic        depth_wr;
  assign cur_depth = ram_rdata[31:16];
  assign depth_wr  = (sd != '0) && ((cur_depth == '0) || (cur_depth > sd));

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (state == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (state == S_WR) begin
      ram_we    = 1'b1;
      ram_wdata = {(depth_wr ? sd : cur_depth), refl};
    end
  end

  lpdi_ram #(
    .WIDTH (32),
    .DEPTH (NPIX)
  ) u_image (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd2048;
      image_height <= 10'd512;
      depth_scale  <= 32'd53687091;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lpdi_pkg::REG_WIDTH:  image_width  <= cfg_data[11:0];
        lpdi_pkg::REG_HEIGHT: image_height <= cfg_data[9:0];
        lpdi_pkg::REG_SCALE:  depth_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      addr     <= '0;
      clr_cmd  <= 1'b0;
      done     <= 1'b0;
      term_vld <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        coef[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          if (addr == LAST_A) begin
            addr            <= '0;
            state           <= S_IDLE;
            done            <= clr_cmd;
            clr_cmd         <= 1'b0;
            status          <= lpdi_pkg::ST_DONE;
            pixel_depth     <= '0;
            pixel_intensity <= '0;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            pixel_depth     <= '0;
            pixel_intensity <= '0;
            status          <= lpdi_pkg::ST_DONE;
            unique case (lpdi_pkg::cmd_t'(cmd))
              lpdi_pkg::CMD_LOAD: begin
                coef[coef_index] <= coef_value;
                done             <= 1'b1;
              end
              lpdi_pkg::CMD_CLEAR: begin
                addr    <= '0;
                clr_cmd <= 1'b1;
                state   <= S_CLEAR;
              end
              lpdi_pkg::CMD_PROJECT: begin
                px    <= point_x;
                py    <= point_y;
                pz    <= point_z;
                refl  <= reflectance;
                idx   <= '0;
                dsel  <= 1'b0;
                for (int i = 0; i < 4; i++) begin
                  acc[i] <= '0;
                end
                state <= S_MAC;
              end
              lpdi_pkg::CMD_READ: begin
                if ((QB'(pixel_col) < MAXW_Q) && (QB'(pixel_row) < MAXH_Q)) begin
                  addr  <= ADDR_W'(pixel_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(pixel_col);
                  state <= S_RREQ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        S_MAC: begin
          // one coefficient per cycle; the last of each row is the offset
          if (idx != 5'd16) begin
            term     <= (idx[1:0] == 2'd3) ? AW'(signed'(coef[idx[3:0]]))
                                           : mul_p[65:FRAC_BITS];
            term_row <= idx[3:2];
            term_vld <= 1'b1;
            idx      <= idx + 1'b1;
          end else begin
            term_vld <= 1'b0;
            state    <= S_DLO;
          end
          if (term_vld) begin
            acc[term_row] <= acc[term_row] + term;
          end
        end
        S_DLO: begin
          plo   <= mul_p[63:0];
          state <= S_DHI;
        end
        S_DHI: begin
          phi   <= mul_p[HW+31:0];
          state <= S_DSUM;
        end
        S_DSUM: begin
          total <= TW'({phi, 32'd0}) + TW'(plo);
          state <= S_DSAT;
        end
        S_DSAT: begin
          if (acc[3][AW-1] || (acc[3] == '0)) begin
            sd <= '0;
          end else if (total >= SAT_THR) begin
            sd <= lpdi_pkg::SAT_DEPTH;
          end else begin
            sd <= 16'((total + HALF_LSB) >> (2 * FRAC_BITS));
          end
          if (acc[2][AW-1] || (acc[2] == '0)) begin
            status <= lpdi_pkg::ST_OUTSIDE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          rem   <= REM_W'(num);
          dsh   <= REM_W'(den) << (QB - 1);
          ovf   <= (REM_W'(num) >= (REM_W'(den) << QB));
          neg   <= div_a[AW-1];
          quot  <= '0;
          bcnt  <= 4'(QB - 1);
          state <= S_DIVS;
        end
        S_DIVS: begin
          if (trial_ok) begin
            rem <= trial;
          end
          quot <= {quot[QB-2:0], trial_ok};
          dsh  <= dsh >> 1;
          bcnt <= bcnt - 1'b1;
          if (bcnt == '0) begin
            state <= S_DIVE;
          end
        end
        S_DIVE: begin
          if (!div_pass) begin
            status <= lpdi_pkg::ST_OUTSIDE;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (!dsel) begin
            colq  <= quot;
            dsel  <= 1'b1;
            state <= S_DIVI;
          end else begin
            rowq  <= quot;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          addr  <= ADDR_W'(rowq) * ADDR_W'(MAX_WIDTH) + ADDR_W'(colq);
          state <= S_RD;
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (sd == '0) begin
            status <= lpdi_pkg::ST_NO_DEPTH;
          end else if (depth_wr) begin
            status <= lpdi_pkg::ST_STORED;
          end else begin
            status <= lpdi_pkg::ST_KEPT;
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_RREQ: begin
          state <= S_RDAT;
        end
        S_RDAT: begin
          pixel_depth     <= ram_rdata[31:16];
          pixel_intensity <= ram_rdata[15:0];
          done            <= 1'b1;
          state           <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result word is only shown once the sequencer is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // image memory is written only by the clearing pass or the z-buffer update
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WR))
    else $error("unexpected image write");

  // every taken command either starts work or answers at once
  a_accept_prog: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("command dropped");

  // a stored or kept depth needs a nonzero scaled depth
  a_depth_status: assert property (@(posedge clk) disable iff (rst)
    (done && (status == lpdi_pkg::ST_STORED || status == lpdi_pkg::ST_KEPT))
      |-> (sd != '0))
    else $error("depth status without depth");

endmodule

>>> test/tb_lidar_point_depth_image_projector.sv
// ----------------------------------------------------------------------------
// tb_lidar_point_depth_image_projector
// Drives load, clear, project and read commands into the projector. A local
// z-buffer predictor works out the expected status and pixel values for each
// accepted command word, and the monitor checks every result word against it.
// ----------------------------------------------------------------------------
module tb_lidar_point_depth_image_projector;

  localparam int         IMG_COLS    = 2048;
  localparam int         IMG_ROWS    = 512;
  localparam int         WDOG_LIMIT  = 3_000_000;
  localparam logic [1:0] REG_SPARE   = 2'd3;   // no register behind this index
  localparam logic [31:0] ONE_Q16    = 32'h0001_0000;
  localparam logic [31:0] SCALE_RST  = 32'd53687091;

  // one command word as the driver presents it
  typedef struct {
    lpdi_pkg::cmd_t     op;
    logic [3:0]         idx;
    logic signed [31:0] cval;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        refl;
    logic [10:0]        col;
    logic [8:0]         row;
  } cmd_word_t;

  // one result word
  typedef struct {
    logic [2:0]  st;
    logic [15:0] depth;
    logic [15:0] intens;
  } pix_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         cmd = lpdi_pkg::CMD_READ;
  logic [3:0]         coef_index = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic [15:0]        reflectance = '0;
  logic [10:0]        pixel_col = '0;
  logic [8:0]         pixel_row = '0;
  logic               done;
  logic [2:0]         status;
  logic [15:0]        pixel_depth;
  logic [15:0]        pixel_intensity;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  lidar_point_depth_image_projector u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cmd            (cmd),
    .coef_index     (coef_index),
    .coef_value     (coef_value),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .reflectance    (reflectance),
    .pixel_col      (pixel_col),
    .pixel_row      (pixel_row),
    .done           (done),
    .status         (status),
    .pixel_depth    (pixel_depth),
    .pixel_intensity(pixel_intensity),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // 8 time unit clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pending command words and expected result words
  cmd_word_t   cmd_backlog[$];
  pix_result_t pix_expected[$];
  cmd_word_t   cur_word;
  logic        taken = 1'b0;
  int          gap_left = 0;
  int          n_errors = 0;
  int          idle_cycles = 0;

  // predictor copy of the block's state
  logic signed [31:0] coef_tab[16];
  logic [15:0]        depth_img[int];
  logic [15:0]        intens_img[int];
  logic [11:0]        cur_width = 12'd2048;
  logic [9:0]         cur_height = 10'd512;
  logic [31:0]        cur_scale = SCALE_RST;

  initial begin
    for (int i = 0; i < 16; i++) coef_tab[i] = '0;
  end

  // one homogeneous row: sum of floored Q16.16 products plus the offset term
  function automatic longint proj_row(int base, longint p0, longint p1, longint p2);
    longint acc;
    acc = longint'(coef_tab[base + 3]);
    acc += (longint'(coef_tab[base]) * p0) >>> 16;
    acc += (longint'(coef_tab[base + 1]) * p1) >>> 16;
    acc += (longint'(coef_tab[base + 2]) * p2) >>> 16;
    return acc;
  endfunction

  // round(a/w) half away from zero, w > 0; a negative pixel is not valid
  function automatic bit pixel_round(longint a, longint w, output longint q);
    longint unsigned mag;
    longint unsigned r;
    mag = (a < 0) ? longint'(-a) : longint'(a);
    r = (2 * mag + longint'(w)) / (2 * longint'(w));
    q = longint'(r);
    return !(a < 0 && r != 0);
  endfunction

  // z-buffer update for one command word, returns the expected result
  function automatic pix_result_t predict_pixel(cmd_word_t w);
    pix_result_t res;
    longint      pu, pv, pw, pd, c, r;
    logic [127:0] prod;
    int          addr, ew, eh;
    logic [15:0] sd;
    res.st = lpdi_pkg::ST_DONE;
    res.depth = '0;
    res.intens = '0;
    case (w.op)
      lpdi_pkg::CMD_LOAD: coef_tab[w.idx] = w.cval;
      lpdi_pkg::CMD_CLEAR: begin
        depth_img.delete();
        intens_img.delete();
      end
      lpdi_pkg::CMD_READ: begin
        addr = int'(w.row) * IMG_COLS + int'(w.col);
        if (depth_img.exists(addr)) res.depth = depth_img[addr];
        if (intens_img.exists(addr)) res.intens = intens_img[addr];
      end
      default: begin
        ew = (cur_width < IMG_COLS) ? int'(cur_width) : IMG_COLS;
        eh = (cur_height < IMG_ROWS) ? int'(cur_height) : IMG_ROWS;
        pu = proj_row(0, w.px, w.py, w.pz);
        pv = proj_row(4, w.px, w.py, w.pz);
        pw = proj_row(8, w.px, w.py, w.pz);
        pd = proj_row(12, w.px, w.py, w.pz);
        res.st = lpdi_pkg::ST_OUTSIDE;
        if (pw > 0 && pixel_round(pu, pw, c) && pixel_round(pv, pw, r) &&
            c < ew && r < eh) begin
          addr = int'(r) * IMG_COLS + int'(c);
          if (pd <= 0) begin
            sd = '0;
          end else begin
            prod = {64'd0, pd[63:0]} * {96'd0, cur_scale};
            if (prod >= (128'h1FFFF << 31)) sd = lpdi_pkg::SAT_DEPTH;
            else sd = 16'((prod + (128'd1 << 31)) >> 32);
          end
          res.st = lpdi_pkg::ST_NO_DEPTH;
          if (sd != 0) begin
            if (!depth_img.exists(addr) || depth_img[addr] == 0 || depth_img[addr] > sd) begin
              depth_img[addr] = sd;
              res.st = lpdi_pkg::ST_STORED;
            end else begin
              res.st = lpdi_pkg::ST_KEPT;
            end
          end
          intens_img[addr] = w.refl;
        end
      end
    endcase
    return res;
  endfunction

  // word builders; fields the command ignores get random values
  function automatic cmd_word_t blank_word(lpdi_pkg::cmd_t op);
    cmd_word_t w;
    w.op = op;
    w.idx = 4'($urandom);
    w.cval = $urandom;
    w.px = $urandom;
    w.py = $urandom;
    w.pz = $urandom;
    w.refl = 16'($urandom);
    w.col = 11'($urandom);
    w.row = 9'($urandom);
    return w;
  endfunction

  task automatic push_load(logic [3:0] idx, logic [31:0] val);
    cmd_word_t w;
    w = blank_word(lpdi_pkg::CMD_LOAD);
    w.idx = idx;
    w.cval = val;
    cmd_backlog.push_back(w);
  endtask

  task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [15:0] rf);
    cmd_word_t w;
    w = blank_word(lpdi_pkg::CMD_PROJECT);
    w.px = x;
    w.py = y;
    w.pz = z;
    w.refl = rf;
    cmd_backlog.push_back(w);
  endtask

  task automatic push_read(int c, int r);
    cmd_word_t w;
    w = blank_word(lpdi_pkg::CMD_READ);
    w.col = 11'(c);
    w.row = 9'(r);
    cmd_backlog.push_back(w);
  endtask

  // pinhole set: u = x, v = y, w = 1, depth = z
  task automatic push_pinhole();
    for (int i = 0; i < 16; i++)
      push_load(4'(i), (i == 0 || i == 5 || i == 11 || i == 14) ? ONE_Q16 : 32'd0);
  endtask

  // Q16.16 coordinate near a pixel center, with a random fraction
  function automatic logic [31:0] near_pixel(int p);
    return 32'((longint'(p) <<< 16) + $signed($urandom_range(0, 65535)) - 32768);
  endfunction

  // driver: new word or hold at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // word still waiting for busy to drop
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (cmd_backlog.size() > 0) begin
      cur_word = cmd_backlog.pop_front();
      cmd <= cur_word.op;
      coef_index <= cur_word.idx;
      coef_value <= cur_word.cval;
      point_x <= cur_word.px;
      point_y <= cur_word.py;
      point_z <= cur_word.pz;
      reflectance <= cur_word.refl;
      pixel_col <= cur_word.col;
      pixel_row <= cur_word.row;
      start <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap_left = 0;
        5, 6, 7, 8:    gap_left = $urandom_range(1, 3);
        default:       gap_left = $urandom_range(10, 80);
      endcase
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: acceptance, result check, config tracking and watchdog
  always @(posedge clk) begin
    pix_result_t want;
    bit          active;
    if (!rst) begin
      active = (start && !busy) || done || (cfg_valid && cfg_ready);
      idle_cycles <= active ? 0 : idle_cycles + 1;
      taken <= start && !busy;
      if (start && !busy) begin
        pix_expected.push_back(predict_pixel(cur_word));
      end
      if (done) begin
        if (pix_expected.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("result word with nothing expected: st=%0d", status);
        end else begin
          want = pix_expected.pop_front();
          if (status !== want.st || pixel_depth !== want.depth ||
              pixel_intensity !== want.intens) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: exp st=%0d depth=%0d int=%0d, got st=%0d depth=%0d int=%0d",
                       want.st, want.depth, want.intens, status, pixel_depth,
                       pixel_intensity);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpdi_pkg::REG_WIDTH:  cur_width <= cfg_data[11:0];
          lpdi_pkg::REG_HEIGHT: cur_height <= cfg_data[9:0];
          lpdi_pkg::REG_SCALE:  cur_scale <= cfg_data;
          default: ;
        endcase
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // wait until every queued word is accepted and answered
  task automatic drain();
    while (cmd_backlog.size() > 0 || start || pix_expected.size() > 0) @(posedge clk);
  endtask

  // three register writes plus one to the spare index, block idle
  task automatic set_config(logic [31:0] wd, logic [31:0] ht, logic [31:0] sc);
    logic [1:0]  idxs[4];
    logic [31:0] vals[4];
    idxs = '{REG_SPARE, lpdi_pkg::REG_WIDTH, lpdi_pkg::REG_HEIGHT, lpdi_pkg::REG_SCALE};
    vals = '{$urandom, wd, ht, sc};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idxs[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly pinhole points near the active area
  task automatic random_phase(int n, int ew, int eh);
    int pick, reload_in;
    reload_in = -1;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        push_point(near_pixel($urandom_range(0, ew + 2) - 1),
                   near_pixel($urandom_range(0, eh + 2) - 1),
                   near_pixel($urandom_range(0, 95) - 3), 16'($urandom));
      else if (pick < 80)
        push_read($urandom_range(0, (ew + 2 > 2047) ? 2047 : ew + 2),
                  $urandom_range(0, (eh + 2 > 511) ? 511 : eh + 2));
      else if (pick < 88)
        push_point($urandom, $urandom, $urandom, 16'($urandom));
      else if (pick < 94)
        push_read($urandom_range(0, 2047), $urandom_range(0, 511));
      else if (pick < 97)
        push_load(4'($urandom), $urandom);
      else
        push_load(4'($urandom_range(0, 15)), ($urandom_range(0, 1) != 0) ? ONE_Q16 : 32'd0);
      if (pick >= 94 && reload_in < 0) reload_in = 6;
      if (reload_in == 0) push_pinhole();
      if (reload_in >= 0) reload_in--;
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: everything but the w term loaded first, so w is zero
    for (int i = 0; i < 16; i++)
      if (i != 11)
        push_load(4'(i), (i == 0 || i == 5 || i == 14) ? ONE_Q16 : 32'd0);
    push_point(near_pixel(3), near_pixel(3), near_pixel(5), 16'hFFFF);
    push_load(4'd11, ONE_Q16);
    push_point(near_pixel(0), near_pixel(0), near_pixel(10), 16'h0001);    // corner, stored
    push_point(near_pixel(0), near_pixel(0), near_pixel(10), 16'h1234);    // same pixel again, kept unless nearer
    push_point(near_pixel(0), near_pixel(0), near_pixel(2), 16'hFFFF);     // nearer, stored
    push_point(near_pixel(2047), near_pixel(511), near_pixel(300), 16'h8000); // saturated depth
    push_point(near_pixel(5), near_pixel(6), 32'hFFF0_0000, 16'h00FF);     // no depth
    push_point(32'hFFFE_0000, near_pixel(2), near_pixel(3), 16'h0F0F);     // negative column
    push_point(near_pixel(2048), near_pixel(2), near_pixel(3), 16'h0F0F);  // column too large
    push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hAAAA);
    push_read(0, 0);
    push_read(2047, 511);
    push_read(5, 6);
    cmd_backlog.push_back(blank_word(lpdi_pkg::CMD_CLEAR));
    push_read(0, 0);
    drain();

    // settings sweep including the extremes of every register
    random_phase(120, 2048, 512);
    set_config(32'd8, 32'd4, SCALE_RST);
    random_phase(120, 8, 4);
    set_config(32'd1, 32'd1, 32'd1);
    random_phase(55, 1, 1);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    random_phase(80, 2047, 511);
    set_config(32'd0, 32'd0, SCALE_RST);
    random_phase(45, 4, 4);
    set_config(32'd16, 32'd8, 32'd0);
    random_phase(55, 16, 8);
    set_config(32'd12, 32'd6, 32'h0100_0000);
    random_phase(80, 12, 6);

    repeat (100) @(posedge clk);
    if (pix_expected.size() != 0) n_errors++;
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/lpdi_pkg.sv
rtl/lpdi_ram.sv
rtl/lidar_point_depth_image_projector.sv
test/tb_lidar_point_depth_image_projector.sv
